FILE: rtl/core/olief_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olief_pkg
// Shared types and codes for the ordered list core.
// ----------------------------------------------------------------------------
package olief_pkg;

  localparam int unsigned OpW     = 3;
  localparam int unsigned PosW    = 6;
  localparam int unsigned ValW    = 32;
  localparam int unsigned StatW   = 2;
  localparam int unsigned CntOutW = 7;

  typedef enum logic [OpW-1:0] {
    OP_PUSH   = 3'd0,
    OP_INSERT = 3'd1,
    OP_ERASE  = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_FIND   = 3'd4,
    OP_READ   = 3'd5,
    OP_WRITE  = 3'd6
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // controller -> datapath commands
  typedef struct packed {
    logic exec;  // apply the accepted word to the cells
    logic load;  // move the finished result into the output register
  } cmd_t;

endpackage

FILE: rtl/core/olief_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olief_if
// Valid/ready channels for request and result words.
// ----------------------------------------------------------------------------
interface olief_in_if;
  import olief_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OpW-1:0]        operation;
  logic [PosW-1:0]       position;
  logic signed [ValW-1:0] value;

  modport source (output valid, operation, position, value, input ready);
  modport sink   (input valid, operation, position, value, output ready);
endinterface

interface olief_out_if;
  import olief_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [StatW-1:0]       status;
  logic [PosW-1:0]        found_position;
  logic signed [ValW-1:0] read_value;
  logic [CntOutW-1:0]     count;

  modport source (output valid, status, found_position, read_value, count, input ready);
  modport sink   (input valid, status, found_position, read_value, count, output ready);
endinterface

FILE: rtl/core/ordered_list_insert_erase_find_core.sv
`timescale 1ns / 1ps
// Result path: the accept edge executes the word into the match, status and read registers;
//   the load edge moves the result into the output register once that register is free.
// Throughput: one request word per cycle unless the output stalls; every cell shifts or
//   compares in parallel at the execute edge; the find encoder uses the registered match row.
// Reset: rst_ni is asynchronous, active low; it empties the list and drops output valid.
//   Entry cells are not reset; only positions below the count are ever read.
// ----------------------------------------------------------------------------
// ordered_list_insert_erase_find_core
// Fixed-capacity ordered list of signed words with push, insert, erase,
// clear, find, read and write, one result word per request word.
// ----------------------------------------------------------------------------
module ordered_list_insert_erase_find_core #(
  parameter int unsigned DEPTH = 64  // entry cells, 2 to 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  olief_in_if.sink    in_i,
  olief_out_if.source out_o
);
  import olief_pkg::*;

  cmd_t cmd;

  // Controller: accepts a request word whenever no finished result is stuck
  // behind a full output register, and moves results into that register.
  olief_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  // Datapath: the request word acts on the cells straight from the port at
  // the execute edge (shift up for insert, down for erase, parallel compare
  // for find). The match row and status are registered; the load edge
  // encodes the lowest hit and fills the output register.
  olief_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .op_i             (in_i.operation),
    .pos_i            (in_i.position),
    .val_i            (in_i.value),
    .status_o         (out_o.status),
    .found_position_o (out_o.found_position),
    .read_value_o     (out_o.read_value),
    .count_o          (out_o.count)
  );

endmodule

FILE: rtl/core/olief_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olief_ctrl
// Handshake controller: issues execute and load commands to the datapath.
// ----------------------------------------------------------------------------
module olief_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output olief_pkg::cmd_t cmd_o
);
  import olief_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_HOLD   // a word has executed, result not yet in the output register
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) || out_free;
  assign cmd_o.exec = in_valid_i && in_ready_o;
  assign cmd_o.load = (state_q == S_HOLD) && out_free;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
      state_d     = S_IDLE;
    end
    if (cmd_o.exec) begin
      state_d = S_HOLD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/core/olief_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olief_dp
// Entry cells, count, parallel compare and result register.
// ----------------------------------------------------------------------------
module olief_dp #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  olief_pkg::cmd_t                  cmd_i,
  input  logic [olief_pkg::OpW-1:0]        op_i,
  input  logic [olief_pkg::PosW-1:0]       pos_i,
  input  logic signed [olief_pkg::ValW-1:0] val_i,
  output logic [olief_pkg::StatW-1:0]      status_o,
  output logic [olief_pkg::PosW-1:0]       found_position_o,
  output logic signed [olief_pkg::ValW-1:0] read_value_o,
  output logic [olief_pkg::CntOutW-1:0]    count_o
);
  import olief_pkg::*;

  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned IW  = $clog2(DEPTH);
  localparam int unsigned XW  = ((CW > PosW) ? CW : PosW) + 1;
  localparam int unsigned EIW = (IW > PosW) ? IW : PosW;
  localparam int unsigned ECW = (CW > CntOutW) ? CW : CntOutW;

  logic [ValW-1:0] cells_q [DEPTH];
  logic [ValW-1:0] cells_d [DEPTH];
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [DEPTH-1:0] match_q, match_d;
  logic            find_q, find_d;
  status_e         stat_q, stat_d;
  logic [ValW-1:0] rdata_q, rdata_d;

  logic [XW-1:0]   cnt_x, pos_x;
  logic            full;
  logic [DEPTH-1:0] low_hit;
  logic [IW-1:0]   hit_idx;
  logic [EIW-1:0]  hit_w;
  logic [ECW-1:0]  cnt_w;
  status_e         stat_fin;

  assign cnt_x = XW'(cnt_q);
  assign pos_x = XW'(pos_i);
  assign full  = (cnt_q == CW'(DEPTH));

  always_comb begin
    cells_d = cells_q;
    cnt_d   = cnt_q;
    stat_d  = ST_OK;
    match_d = '0;
    rdata_d = '0;
    find_d  = 1'b0;
    unique case (op_e'(op_i))
      OP_PUSH: begin
        if (full) begin
          stat_d = ST_FULL;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (XW'(i) == cnt_x) cells_d[i] = val_i;
          end
          cnt_d = cnt_q + 1'b1;
        end
      end
      OP_INSERT: begin
        if (pos_x > cnt_x) begin
          stat_d = ST_BAD_POS;
        end else if (full) begin
          stat_d = ST_FULL;
        end else begin
          for (int i = 1; i < DEPTH; i++) begin
            if (XW'(i) > pos_x) cells_d[i] = cells_q[i-1];
          end
          for (int i = 0; i < DEPTH; i++) begin
            if (XW'(i) == pos_x) cells_d[i] = val_i;
          end
          cnt_d = cnt_q + 1'b1;
        end
      end
      OP_ERASE: begin
        if (pos_x >= cnt_x) begin
          stat_d = ST_BAD_POS;
        end else begin
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (XW'(i) >= pos_x) cells_d[i] = cells_q[i+1];
          end
          cnt_d = cnt_q - 1'b1;
        end
      end
      OP_CLEAR: begin
        cnt_d = '0;
      end
      OP_FIND: begin
        find_d = 1'b1;
        for (int i = 0; i < DEPTH; i++) begin
          match_d[i] = (XW'(i) < cnt_x) && (cells_q[i] == val_i);
        end
      end
      OP_READ: begin
        if (pos_x >= cnt_x) stat_d = ST_BAD_POS;
        else                rdata_d = cells_q[pos_x[IW-1:0]];
      end
      OP_WRITE: begin
        if (pos_x >= cnt_x) begin
          stat_d = ST_BAD_POS;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (XW'(i) == pos_x) cells_d[i] = val_i;
          end
        end
      end
      default: ;  // unused code: no change, ok status
    endcase
  end

  // lowest set match bit, then one-hot to binary
  assign low_hit = match_q & (~match_q + 1'b1);

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (low_hit[i]) hit_idx = hit_idx | IW'(i);
    end
  end

  assign hit_w    = EIW'(hit_idx);
  assign cnt_w    = ECW'(cnt_q);
  assign stat_fin = find_q ? ((|match_q) ? ST_OK : ST_NOT_FOUND) : stat_q;

  // entry cells: no reset, only entries below the count are ever read
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) cells_q <= cells_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) rdata_q <= rdata_d;
    if (cmd_i.load) begin
      found_position_o <= (find_q && (|match_q)) ? hit_w[PosW-1:0] : '0;
      read_value_o     <= rdata_q;
      count_o          <= cnt_w[CntOutW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      match_q  <= '0;
      find_q   <= 1'b0;
      stat_q   <= ST_OK;
      status_o <= '0;
    end else begin
      if (cmd_i.exec) begin
        cnt_q   <= cnt_d;
        match_q <= match_d;
        find_q  <= find_d;
        stat_q  <= stat_d;
      end
      if (cmd_i.load) status_o <= stat_fin;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count above capacity");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && (op_i == OP_PUSH) && !full) |=> (cnt_q == CW'($past(cnt_q) + 1'b1)))
    else $error("push did not grow the count by one");

  a_match_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (match_q != '0) |-> (CW'(hit_idx) < cnt_q))
    else $error("find hit at or above the count");
`endif

endmodule

FILE: tb/ordered_list_insert_erase_find_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_insert_erase_find_core_tb
// Drives request words at the list core under random gaps and output stalls,
// predicts each result word from a local copy of the list and checks every
// field of every result word in order.
// ----------------------------------------------------------------------------
module ordered_list_insert_erase_find_core_tb;
  import olief_pkg::*;

  localparam int unsigned LIST_DEPTH = 64;
  localparam time         CLK_HALF   = 10ns;
  localparam logic [OpW-1:0] OP_NONE = 3'd7;  // no meaning, must leave the list alone

  // stimulus and traffic shaping
  localparam int unsigned RAND_WORDS   = 800;
  localparam int unsigned IDLE_PCT     = 29;
  localparam int unsigned SEND_QUIET_LO = 300;  // sender never idles in this word range
  localparam int unsigned SEND_QUIET_HI = 420;
  localparam int unsigned RECV_QUIET_LO = 300;  // receiver never stalls in this range
  localparam int unsigned RECV_QUIET_HI = 420;
  localparam int unsigned HOLD_AT      = 200;   // long output hold starts here
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [OpW-1:0]         op;
    logic [PosW-1:0]        pos;
    logic signed [ValW-1:0] val;
  } req_t;

  typedef struct packed {
    status_e                status;
    logic [PosW-1:0]        found;
    logic signed [ValW-1:0] rdata;
    logic [CntOutW-1:0]     cnt;
  } rsp_t;

  typedef enum int {FILL, MIXED, DRAIN} mix_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  olief_in_if  req_if ();
  olief_out_if rsp_if ();

  ordered_list_insert_erase_find_core #(
    .DEPTH (LIST_DEPTH)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // local copy of the list
  logic signed [ValW-1:0] list_mem [LIST_DEPTH];
  int unsigned            list_len;

  req_t        pending_q [$];
  rsp_t        result_q  [$];
  int unsigned words_sent;
  int unsigned words_seen;
  int unsigned err_cnt;
  int unsigned status_hits [4];
  int unsigned full_hits;
  int unsigned hold_left;
  bit          hold_done;

  // generator side: track only the length so positions land in range
  int unsigned            gen_len;
  logic signed [ValW-1:0] val_pool [8];

  // apply one request word to the local list and return its result word
  function automatic rsp_t apply_request(req_t r);
    rsp_t res;
    int   i;
    res = '{status: ST_OK, found: '0, rdata: '0, cnt: '0};
    case (r.op)
      OP_PUSH: begin
        if (list_len >= LIST_DEPTH) res.status = ST_FULL;
        else begin
          list_mem[list_len] = r.val;
          list_len++;
        end
      end
      OP_INSERT: begin
        if (r.pos > list_len) res.status = ST_BAD_POS;
        else if (list_len >= LIST_DEPTH) res.status = ST_FULL;
        else begin
          for (i = list_len; i > r.pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[r.pos] = r.val;
          list_len++;
        end
      end
      OP_ERASE: begin
        if (r.pos >= list_len) res.status = ST_BAD_POS;
        else begin
          for (i = r.pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      OP_CLEAR: list_len = 0;
      OP_FIND: begin
        res.status = ST_NOT_FOUND;
        for (i = 0; i < list_len; i++) begin
          if (list_mem[i] == r.val) begin
            res.status = ST_OK;
            res.found  = i[PosW-1:0];
            break;
          end
        end
      end
      OP_READ: begin
        if (r.pos >= list_len) res.status = ST_BAD_POS;
        else res.rdata = list_mem[r.pos];
      end
      OP_WRITE: begin
        if (r.pos >= list_len) res.status = ST_BAD_POS;
        else list_mem[r.pos] = r.val;
      end
      default: ;
    endcase
    res.cnt = list_len[CntOutW-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on result %0d: %s got %0d want %0d",
             $realtime, words_seen, what, got, want);
    err_cnt++;
  endtask

  task automatic queue_word(logic [OpW-1:0] op, logic [PosW-1:0] pos,
                            logic signed [ValW-1:0] val);
    pending_q.push_back('{op: op, pos: pos, val: val});
    case (op)
      OP_PUSH:   if (gen_len < LIST_DEPTH) gen_len++;
      OP_INSERT: if (pos <= gen_len && gen_len < LIST_DEPTH) gen_len++;
      OP_ERASE:  if (pos < gen_len) gen_len--;
      OP_CLEAR:  gen_len = 0;
      default: ;
    endcase
  endtask

  function automatic logic [OpW-1:0] pick_op(mix_e mix);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (mix)
      FILL: begin
        if (roll < 40)      return OP_PUSH;
        else if (roll < 80) return OP_INSERT;
        else if (roll < 88) return OP_FIND;
        else if (roll < 92) return OP_READ;
        else if (roll < 96) return OP_WRITE;
        else if (roll < 99) return OP_ERASE;
        else                return OP_NONE;
      end
      DRAIN: begin
        if (roll < 55)      return OP_ERASE;
        else if (roll < 70) return OP_FIND;
        else if (roll < 80) return OP_READ;
        else if (roll < 90) return OP_WRITE;
        else if (roll < 95) return OP_PUSH;
        else                return OP_INSERT;
      end
      default: begin
        if (roll < 2)       return OP_CLEAR;
        else if (roll < 4)  return OP_NONE;
        else if (roll < 20) return OP_PUSH;
        else if (roll < 36) return OP_INSERT;
        else if (roll < 52) return OP_ERASE;
        else if (roll < 68) return OP_FIND;
        else if (roll < 84) return OP_READ;
        else                return OP_WRITE;
      end
    endcase
  endfunction

  // well-formed position most of the time, anything in the field otherwise
  function automatic logic [PosW-1:0] pick_pos(logic [OpW-1:0] op);
    int unsigned top;
    if ($urandom_range(0, 9) == 0) return PosW'($urandom_range(0, 63));
    if (op == OP_INSERT) top = (gen_len > 63) ? 63 : gen_len;
    else if (gen_len == 0) return PosW'($urandom_range(0, 63));
    else top = gen_len - 1;
    return PosW'($urandom_range(0, top));
  endfunction

  // reuse a small pool so finds hit and duplicates show up
  function automatic logic signed [ValW-1:0] pick_val(logic [OpW-1:0] op);
    if ($urandom_range(0, 99) < ((op == OP_FIND) ? 60 : 40))
      return val_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // request driver: load the next word whenever the slot is free
  always @(posedge clk_i or negedge rst_ni) begin
    req_t nxt;
    bit   idle_now;
    if (!rst_ni) begin
      req_if.valid     <= 1'b0;
      req_if.operation <= '0;
      req_if.position  <= '0;
      req_if.value     <= '0;
      words_sent       <= 0;
    end else if (!req_if.valid || req_if.ready) begin
      if (req_if.valid) begin
        result_q.push_back(apply_request('{op: req_if.operation, pos: req_if.position,
                                           val: req_if.value}));
        words_sent <= words_sent + 1;
      end
      idle_now = !(words_sent >= SEND_QUIET_LO && words_sent < SEND_QUIET_HI) &&
                 ($urandom_range(0, 99) < IDLE_PCT);
      if (pending_q.size() != 0 && !idle_now) begin
        nxt = pending_q.pop_front();
        req_if.operation <= nxt.op;
        req_if.position  <= nxt.pos;
        req_if.value     <= nxt.val;
        req_if.valid     <= 1'b1;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // one long output hold while the sender keeps offering words
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_sent >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor and output stall generator
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    bit   quiet;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      words_seen   <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (result_q.size() == 0) begin
          $display("[%0t] unexpected result word, nothing outstanding", $realtime);
          err_cnt++;
        end else begin
          want = result_q.pop_front();
          if (rsp_if.status != want.status)
            report_mismatch("status", rsp_if.status, want.status);
          if (rsp_if.found_position != want.found)
            report_mismatch("found_position", rsp_if.found_position, want.found);
          if (rsp_if.read_value != want.rdata)
            report_mismatch("read_value", rsp_if.read_value, want.rdata);
          if (rsp_if.count != want.cnt)
            report_mismatch("count", rsp_if.count, want.cnt);
          status_hits[want.status]++;
          if (want.status == ST_FULL) full_hits++;
        end
        words_seen <= words_seen + 1;
      end
      quiet = (words_seen >= RECV_QUIET_LO && words_seen < RECV_QUIET_HI);
      rsp_if.ready <= (hold_left == 0) && (quiet || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    mix_e              mix;
    logic [OpW-1:0]    op;
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.operation = '0;
    req_if.position  = '0;
    req_if.value     = '0;
    rsp_if.ready     = 1'b0;
    list_len         = 0;
    gen_len          = 0;
    err_cnt          = 0;
    full_hits        = 0;
    status_hits      = '{default: 0};
    val_pool = '{32'sh7fffffff, 32'sh80000000, 32'sh0, -32'sd1,
                 $urandom, $urandom, 32'sh5a5a5a5a, 32'sha5a5a5a5};

    // directed: empty list corners, edge values, middle shifts, duplicates
    queue_word(OP_FIND,   6'd0,  32'sd5);         // find on empty list
    queue_word(OP_READ,   6'd0,  32'sd0);         // read at the count
    queue_word(OP_ERASE,  6'd0,  32'sd0);
    queue_word(OP_WRITE,  6'd0,  -32'sd1);
    queue_word(OP_INSERT, 6'd3,  32'sd7);         // insert above the count
    queue_word(OP_INSERT, 6'd0,  32'sh7fffffff);  // insert at the count acts as push
    queue_word(OP_PUSH,   6'd63, 32'sh80000000);
    queue_word(OP_PUSH,   6'd0,  32'sd0);
    queue_word(OP_PUSH,   6'd0,  -32'sd1);
    queue_word(OP_INSERT, 6'd1,  32'sh5a5a5a5a);  // middle insert shifts up
    queue_word(OP_INSERT, 6'd0,  32'sd0);         // duplicate zero at the front
    queue_word(OP_FIND,   6'd0,  32'sd0);         // lowest of two matches
    queue_word(OP_FIND,   6'd63, -32'sd1);
    queue_word(OP_READ,   6'd63, 32'sd0);
    queue_word(OP_READ,   6'd2,  32'sd0);
    queue_word(OP_WRITE,  6'd5,  32'sha5a5a5a5);  // last entry
    queue_word(OP_WRITE,  6'd6,  32'sd1);         // one past the end
    queue_word(OP_ERASE,  6'd0,  32'sd0);         // first entry shifts all down
    queue_word(OP_ERASE,  6'd4,  32'sd0);         // last entry
    queue_word(OP_ERASE,  6'd63, 32'sd0);
    queue_word(OP_INSERT, 6'd63, 32'sd3);
    queue_word(OP_NONE,   6'd63, -32'sd1);        // unused code
    queue_word(OP_FIND,   6'd0,  32'sh5a5a5a5a);
    queue_word(OP_CLEAR,  6'd0,  32'sd0);
    queue_word(OP_FIND,   6'd0,  32'sd0);         // find after clear

    // random: fill to full, churn, drain, repeat
    for (int unsigned n = 0; n < RAND_WORDS; n++) begin
      case ((n / 100) % 3)
        0:       mix = FILL;
        1:       mix = MIXED;
        default: mix = DRAIN;
      endcase
      op = pick_op(mix);
      queue_word(op, pick_pos(op), pick_val(op));
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || req_if.valid) @(posedge clk_i);
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d request words and %0d result words, list full %0d times",
             words_sent, words_seen, full_hits);
    $display("statuses: ok %0d, bad position %0d, full %0d, not found %0d",
             status_hits[ST_OK], status_hits[ST_BAD_POS], status_hits[ST_FULL],
             status_hits[ST_NOT_FOUND]);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #4ms;
    $display("FAIL");
    $finish;
  end

endmodule
